// ===== design/srs_pkg.sv =====
// shared widths, constants and types for the sample run statistics block
package srs_pkg;

  localparam int unsigned MaxSamples = 65536;
  localparam int unsigned SampleBits = 12;

  localparam int unsigned CountW = $clog2(MaxSamples + 1);
  localparam int unsigned SumW   = SampleBits + $clog2(MaxSamples);
  localparam int unsigned SqW    = 2 * SampleBits + $clog2(MaxSamples);

  localparam int unsigned MulAW  = CountW + SampleBits;
  localparam int unsigned MulPW  = MulAW + SampleBits;
  localparam int unsigned VarW   = SqW + 2;

  localparam int unsigned DivW    = SqW;
  localparam int unsigned DivCntW = $clog2(DivW);

  localparam int unsigned RootW   = SampleBits;
  localparam int unsigned RadW    = 2 * RootW;
  localparam int unsigned RootCntW = $clog2(RootW);

  typedef struct packed {
    logic [CountW-1:0]     count;
    logic [SumW-1:0]       sum;
    logic [SqW-1:0]        sumsq;
    logic [SampleBits-1:0] min;
    logic [SampleBits-1:0] max;
    logic                  ovf;
  } run_t;

  localparam run_t RunClear = '{
    count: '0,
    sum:   '0,
    sumsq: '0,
    min:   '1,
    max:   '0,
    ovf:   1'b0
  };

endpackage

// ===== design/srs_acc.sv =====
// run accumulator: count, sum, sum of squares, minimum, maximum, overflow flag
module srs_acc (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          clr_i,
  input  logic [11:0]   sample_i,
  output srs_pkg::run_t run_o
);
  import srs_pkg::*;

  logic [SampleBits-1:0]   x;
  logic [2*SampleBits-1:0] x_sq;
  run_t                    run_q, run_d;

  assign x    = sample_i[SampleBits-1:0];
  assign x_sq = x * x;

  always_comb begin
    run_d = run_q;
    if (clr_i) begin
      run_d = RunClear;
    end else if (en_i) begin
      if (run_q.count == CountW'(MaxSamples)) begin
        run_d.ovf = 1'b1;
      end else begin
        run_d.count = run_q.count + CountW'(1);
        run_d.sum   = run_q.sum + SumW'(x);
        run_d.sumsq = run_q.sumsq + SqW'(x_sq);
        if (x < run_q.min) run_d.min = x;
        if (x > run_q.max) run_d.max = x;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= RunClear;
    end else begin
      run_q <= run_d;
    end
  end

  assign run_o = run_q;

endmodule

// ===== design/srs_div.sv =====
// restoring divider, one quotient bit per cycle
module srs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [srs_pkg::DivW-1:0]   dividend_i,
  input  logic [srs_pkg::CountW-1:0] divisor_i,
  output logic [srs_pkg::DivW-1:0]   quotient_o,
  output logic                       done_o
);
  import srs_pkg::*;

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivW-1:0]    work_q;
  logic [CountW-1:0]  rem_q;
  logic [CountW-1:0]  div_q;
  logic [CountW:0]    rem_sh;
  logic [CountW+1:0]  diff;
  logic               ge;
  logic [CountW-1:0]  rem_nxt;

  assign rem_sh  = {rem_q, work_q[DivW-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, div_q};
  assign ge      = !diff[CountW+1];
  assign rem_nxt = ge ? diff[CountW-1:0] : rem_sh[CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      work_q <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivW - 1);
        work_q <= dividend_i;
        rem_q  <= '0;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        work_q <= {work_q[DivW-2:0], ge};
        rem_q  <= rem_nxt;
        cnt_q  <= cnt_q - DivCntW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o = work_q;
  assign done_o     = done_q;

endmodule

// ===== design/srs_sqrt.sv =====
// integer square root, one root bit per cycle
module srs_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [srs_pkg::RadW-1:0]  radicand_i,
  output logic [srs_pkg::RootW-1:0] root_o,
  output logic                      done_o
);
  import srs_pkg::*;

  logic                busy_q, done_q;
  logic [RootCntW-1:0] cnt_q;
  logic [RadW-1:0]     rad_q;
  logic [RootW-1:0]    root_q;
  logic [RootW+1:0]    rem_q;
  logic [RootW+3:0]    rem_sh;
  logic [RootW+4:0]    diff;
  logic                ge;

  assign rem_sh = {rem_q, rad_q[RadW-1:RadW-2]};
  assign diff   = {1'b0, rem_sh} - (RootW+5)'({root_q, 2'b01});
  assign ge     = !diff[RootW+4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      root_q <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= RootCntW'(RootW - 1);
        rad_q  <= radicand_i;
        root_q <= '0;
        rem_q  <= '0;
      end else if (busy_q) begin
        rad_q  <= {rad_q[RadW-3:0], 2'b00};
        root_q <= {root_q[RootW-2:0], ge};
        rem_q  <= ge ? diff[RootW+1:0] : rem_sh[RootW+1:0];
        cnt_q  <= cnt_q - RootCntW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// ===== design/sample_run_statistics.sv =====
// top level: run statistics with shared multiplier, divider and root sequencer
//
// A sample beat is taken at a rising edge with start high and busy low; each
// beat carries one 12-bit unsigned sample and last_sample, which closes the run.
// Samples that do not close the run are absorbed one per cycle: busy stays low.
// A beat with last_sample set raises busy while the block computes the mean
// (shared restoring divider, one bit a cycle), the sum of squared deviations
// (one shared multiplier over three steps), that sum over the count (divider
// again) and its square root (one root bit a cycle).
// result_valid_o pulses for one cycle after the root is done, with mean,
// minimum, maximum, deviation, sample_count and count_overflow; in that
// same cycle busy is low again, so the next sample beat can be taken.
// Samples beyond the maximum count only set count_overflow.
// The receiver cannot stall: the result is shown for a single cycle only.
// Reset clears the run totals and the sequencer; no result is pending.
module sample_run_statistics (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] sample_i,
  input  logic        last_sample_i,
  output logic        result_valid_o,
  output logic [11:0] mean_o,
  output logic [11:0] minimum_o,
  output logic [11:0] maximum_o,
  output logic [10:0] deviation_o,
  output logic [16:0] sample_count_o,
  output logic        count_overflow_o
);
  import srs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_MUL_CM,
    S_MUL_CMM,
    S_MUL_MS,
    S_VAR_GO,
    S_VAR_WAIT,
    S_ROOT_GO,
    S_ROOT_WAIT
  } state_e;

  state_e                state_q;
  run_t                  run;
  logic                  acc_en, acc_clr;
  logic                  div_start, div_done;
  logic [DivW-1:0]       div_dividend, div_quot;
  logic                  sqrt_start, sqrt_done;
  logic [RootW-1:0]      root;
  logic [SampleBits-1:0] mean_q;
  logic [MulPW-1:0]      prod_q;
  logic [VarW-1:0]       var_q;
  logic [MulAW-1:0]      mul_a;
  logic [MulPW-1:0]      mul_p;
  logic                  valid_q;
  logic [11:0]           mean_out_q, min_out_q, max_out_q;
  logic [10:0]           dev_out_q;
  logic [16:0]           count_out_q;
  logic                  ovf_out_q;

  assign busy       = (state_q != S_IDLE);
  assign acc_en     = start && !busy;
  assign acc_clr    = (state_q == S_ROOT_WAIT) && sqrt_done;
  assign div_start  = (state_q == S_MEAN_GO) || (state_q == S_VAR_GO);
  assign sqrt_start = (state_q == S_ROOT_GO);
  assign div_dividend = (state_q == S_MEAN_GO) ? DivW'(run.sum) : var_q[DivW-1:0];

  always_comb begin
    unique case (state_q)
      S_MUL_CM:  mul_a = MulAW'(run.count);
      S_MUL_CMM: mul_a = prod_q[MulAW-1:0];
      S_MUL_MS:  mul_a = MulAW'(run.sum);
      default:   mul_a = '0;
    endcase
  end

  assign mul_p = MulPW'(mul_a) * MulPW'(mean_q);

  srs_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (acc_en),
    .clr_i    (acc_clr),
    .sample_i (sample_i),
    .run_o    (run)
  );

  srs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (run.count),
    .quotient_o (div_quot),
    .done_o     (div_done)
  );

  srs_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (div_quot[RadW-1:0]),
    .root_o     (root),
    .done_o     (sqrt_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= 1'b0;
      mean_q      <= '0;
      prod_q      <= '0;
      var_q       <= '0;
      mean_out_q  <= '0;
      min_out_q   <= '0;
      max_out_q   <= '0;
      dev_out_q   <= '0;
      count_out_q <= '0;
      ovf_out_q   <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (acc_en && last_sample_i) state_q <= S_MEAN_GO;
        end
        S_MEAN_GO: begin
          state_q <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (div_done) begin
            mean_q  <= div_quot[SampleBits-1:0];
            state_q <= S_MUL_CM;
          end
        end
        S_MUL_CM: begin
          prod_q  <= mul_p;
          state_q <= S_MUL_CMM;
        end
        S_MUL_CMM: begin
          var_q   <= VarW'(run.sumsq) + VarW'(mul_p);
          state_q <= S_MUL_MS;
        end
        S_MUL_MS: begin
          var_q   <= var_q - (VarW'(mul_p) << 1);
          state_q <= S_VAR_GO;
        end
        S_VAR_GO: begin
          state_q <= S_VAR_WAIT;
        end
        S_VAR_WAIT: begin
          if (div_done) state_q <= S_ROOT_GO;
        end
        S_ROOT_GO: begin
          state_q <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (sqrt_done) begin
            mean_out_q  <= 12'(mean_q);
            min_out_q   <= 12'(run.min);
            max_out_q   <= 12'(run.max);
            dev_out_q   <= root[10:0];
            count_out_q <= 17'(run.count);
            ovf_out_q   <= run.ovf;
            valid_q     <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o   = valid_q;
  assign mean_o           = mean_out_q;
  assign minimum_o        = min_out_q;
  assign maximum_o        = max_out_q;
  assign deviation_o      = dev_out_q;
  assign sample_count_o   = count_out_q;
  assign count_overflow_o = ovf_out_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the sample run statistics block: queued beats and a stats predictor
module testbench;
  import srs_pkg::*;

  typedef struct {
    logic [11:0] value;
    logic        closes;
    int unsigned gap;
  } sample_beat_t;

  typedef struct {
    logic [11:0] mean;
    logic [11:0] minimum;
    logic [11:0] maximum;
    logic [10:0] deviation;
    logic [16:0] count;
    logic        overflow;
  } run_stats_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [11:0] sample_i = '0;
  logic        last_sample_i = 1'b0;
  logic        result_valid_o;
  logic [11:0] mean_o;
  logic [11:0] minimum_o;
  logic [11:0] maximum_o;
  logic [10:0] deviation_o;
  logic [16:0] sample_count_o;
  logic        count_overflow_o;

  sample_beat_t pending_samples[$];
  run_stats_t   stats_due[$];
  int unsigned  failures = 0;

  logic [CountW-1:0]     acc_count = '0;
  logic [SumW-1:0]       acc_sum = '0;
  logic [SqW-1:0]        acc_sumsq = '0;
  logic [SampleBits-1:0] acc_min = '1;
  logic [SampleBits-1:0] acc_max = '0;
  logic                  acc_ovf = 1'b0;

  sample_run_statistics dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .sample_i        (sample_i),
    .last_sample_i   (last_sample_i),
    .result_valid_o  (result_valid_o),
    .mean_o          (mean_o),
    .minimum_o       (minimum_o),
    .maximum_o       (maximum_o),
    .deviation_o     (deviation_o),
    .sample_count_o  (sample_count_o),
    .count_overflow_o(count_overflow_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  task automatic fold_sample(input logic [11:0] value, input logic closes);
    longint unsigned cnt;
    longint unsigned tot;
    longint unsigned avg;
    longint unsigned spread;
    run_stats_t stats;
    if (acc_count >= CountW'(MaxSamples)) begin
      acc_ovf = 1'b1;
    end else begin
      acc_count = acc_count + CountW'(1);
      acc_sum   = acc_sum + SumW'(value);
      acc_sumsq = acc_sumsq + SqW'(value) * SqW'(value);
      if (value < acc_min) acc_min = value;
      if (value > acc_max) acc_max = value;
    end
    if (closes) begin
      cnt    = 64'(acc_count);
      tot    = 64'(acc_sum);
      avg    = tot / cnt;
      spread = 64'(acc_sumsq) + cnt * avg * avg - 64'd2 * avg * tot;
      stats.mean      = avg[11:0];
      stats.minimum   = acc_min;
      stats.maximum   = acc_max;
      stats.deviation = 11'(floor_root(spread / cnt));
      stats.count     = acc_count;
      stats.overflow  = acc_ovf;
      stats_due.push_back(stats);
      acc_count = '0;
      acc_sum   = '0;
      acc_sumsq = '0;
      acc_min   = '1;
      acc_max   = '0;
      acc_ovf   = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    sample_beat_t nxt;
    if (rst_ni) begin
      if (start && !busy) fold_sample(sample_i, last_sample_i);
      if (!start || !busy) begin
        if (pending_samples.size() == 0) begin
          start <= 1'b0;
        end else if (pending_samples[0].gap != 0) begin
          pending_samples[0].gap = pending_samples[0].gap - 1;
          start <= 1'b0;
        end else begin
          nxt = pending_samples.pop_front();
          start         <= 1'b1;
          sample_i      <= nxt.value;
          last_sample_i <= nxt.closes;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    run_stats_t want;
    if (rst_ni && result_valid_o) begin
      if (stats_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got mean %0d count %0d",
                 $time, mean_o, sample_count_o);
        failures++;
      end else begin
        want = stats_due.pop_front();
        check_field("mean", want.mean, mean_o);
        check_field("minimum", want.minimum, minimum_o);
        check_field("maximum", want.maximum, maximum_o);
        check_field("deviation", want.deviation, deviation_o);
        check_field("sample_count", want.count, sample_count_o);
        check_field("count_overflow", want.overflow, count_overflow_o);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [11:0] pick_sample(input int unsigned mode, input int unsigned base);
    int unsigned v;
    case (mode)
      0: v = $urandom_range(0, 4095);
      1: begin
        v = base + $urandom_range(0, 24);
        if (v > 4095) v = 4095;
      end
      2: v = $urandom_range(0, 1) ? 4095 - $urandom_range(0, 2) : $urandom_range(0, 2);
      default: v = base;
    endcase
    return v[11:0];
  endfunction

  task automatic queue_sample(input logic [11:0] value, input logic closes, input int unsigned gap);
    sample_beat_t b;
    b.value  = value;
    b.closes = closes;
    b.gap    = gap;
    pending_samples.push_back(b);
  endtask

  initial begin
    int unsigned random_items;
    int unsigned run_len;
    int unsigned mode;
    int unsigned base;
    bit          burst;

    // single-sample runs at both extremes, then short extreme runs
    queue_sample(12'd0, 1'b1, pick_gap());
    queue_sample(12'd4095, 1'b1, pick_gap());
    queue_sample(12'd0, 1'b0, pick_gap());
    queue_sample(12'd4095, 1'b1, pick_gap());
    for (int i = 0; i < 3; i++) queue_sample(12'd4095, i == 2, pick_gap());
    for (int b = 0; b < 12; b++) queue_sample(12'd1 << b, b == 11, pick_gap());
    queue_sample(12'd2048, 1'b0, pick_gap());
    queue_sample(12'd2047, 1'b0, pick_gap());
    queue_sample(12'd0, 1'b0, pick_gap());
    queue_sample(12'd4095, 1'b1, pick_gap());

    // run filling the count exactly, then one that overflows with extremes beyond it
    for (int i = 0; i < MaxSamples; i++)
      queue_sample(12'($urandom_range(100, 3000)), i == MaxSamples - 1,
                   ($urandom_range(0, 15) == 0) ? $urandom_range(1, 3) : 0);
    for (int i = 0; i < MaxSamples; i++)
      queue_sample(12'($urandom_range(100, 3000)), 1'b0,
                   ($urandom_range(0, 15) == 0) ? $urandom_range(1, 3) : 0);
    queue_sample(12'd0, 1'b0, 0);
    queue_sample(12'd4095, 1'b1, pick_gap());

    random_items = 0;
    while (random_items < 850) begin
      run_len = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 12) : $urandom_range(13, 48);
      mode    = $urandom_range(0, 3);
      base    = $urandom_range(0, 4095);
      burst   = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < run_len; i++)
        queue_sample(pick_sample(mode, base), i == run_len - 1, burst ? 0 : pick_gap());
      random_items += run_len;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_samples.size() != 0 || start || stats_due.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
design/srs_pkg.sv
design/srs_acc.sv
design/srs_div.sv
design/srs_sqrt.sv
design/sample_run_statistics.sv
tb/testbench.sv
